// ===== hdl/dip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_pkg: shared types and constants of the decimal parser
// Character classes, the queue entry between front and back, queue sizing.
// ----------------------------------------------------------------------------
package dip_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_MINUS = 2'd1,
    CLS_OTHER = 2'd2
  } char_cls_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic       last;
  } q_entry_t;

endpackage

// ===== hdl/dip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_front: character classifier
// Sorts each incoming character into digit, minus or other and forms the
// queue entry.
// ----------------------------------------------------------------------------
module dip_front (
  input  logic              in_push,
  input  logic [7:0]        in_char_code,
  input  logic              in_is_last,
  input  logic              q_full,
  output logic              q_push,
  output dip_pkg::q_entry_t q_wdata
);

  logic [7:0] offs;

  assign offs = in_char_code - dip_pkg::CH_ZERO;

  always_comb begin
    q_wdata.last  = in_is_last;
    q_wdata.digit = offs[3:0];
    if (in_char_code inside {[dip_pkg::CH_ZERO:dip_pkg::CH_NINE]}) begin
      q_wdata.cls = dip_pkg::CLS_DIGIT;
    end else if (in_char_code == dip_pkg::CH_MINUS) begin
      q_wdata.cls = dip_pkg::CLS_MINUS;
    end else begin
      q_wdata.cls = dip_pkg::CLS_OTHER;
    end
  end

  assign q_push = in_push & ~q_full;

endmodule

// ===== hdl/dip_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_queue: short queue between classifier and accumulator
// Small register queue so front and back stall independently.
// ----------------------------------------------------------------------------
module dip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dip_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output dip_pkg::q_entry_t rdata
);

  dip_pkg::q_entry_t mem [dip_pkg::Q_DEPTH];

  logic [dip_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dip_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dip_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full    = (cnt_r == (dip_pkg::Q_AW+1)'(dip_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/dip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_back: accumulator and result register
// Folds digits into the magnitude, tracks sign, count and errors, and
// holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module dip_back #(
  parameter int unsigned MAX_CHARS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  dip_pkg::q_entry_t         q_rdata,
  output logic                      q_pop,
  output logic                      res_valid,
  output logic [dip_pkg::VAL_W-1:0] res_mag,
  output logic                      res_neg,
  output logic                      res_bad,
  input  logic                      res_pop
);

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 2);
  localparam int unsigned W     = dip_pkg::VAL_W;

  logic [W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             inv_r, inv_nxt;

  logic             res_valid_r, res_valid_nxt;
  logic [W-1:0]     res_mag_r, res_mag_nxt;
  logic             res_neg_r, res_neg_nxt;
  logic             res_bad_r, res_bad_nxt;

  logic [W+3:0]     prod;
  logic [W-1:0]     acc_c;
  logic [CNT_W-1:0] cnt_c;
  logic             neg_c, inv_c, bad, range_bad, take;

  // result slot free now or emptied this cycle
  assign take = ~q_empty & (~q_rdata.last | ~res_valid_r | res_pop);
  assign q_pop = take;

  // acc * 10 + digit, carries above bit 63 mean overflow
  assign prod = (W+4)'({acc_r, 3'b000}) + (W+4)'({acc_r, 1'b0}) + (W+4)'(q_rdata.digit);

  always_comb begin
    acc_c = acc_r;
    neg_c = neg_r;
    inv_c = inv_r;
    cnt_c = (cnt_r <= CNT_W'(MAX_CHARS)) ? cnt_r + 1'b1 : cnt_r;
    if (cnt_c > CNT_W'(MAX_CHARS)) begin
      inv_c = 1'b1;
    end else if (!inv_r) begin
      if ((cnt_r == '0) && (q_rdata.cls == dip_pkg::CLS_MINUS)) begin
        neg_c = 1'b1;
      end else if (q_rdata.cls != dip_pkg::CLS_DIGIT) begin
        inv_c = 1'b1;
      end else if (prod[W+3:W] != '0) begin
        inv_c = 1'b1;
      end else begin
        acc_c = prod[W-1:0];
      end
    end

    // magnitude limit is 2^63 for negative, 2^63 - 1 otherwise
    range_bad = acc_c[W-1] & (~neg_c | (acc_c[W-2:0] != '0));
    bad = inv_c | (neg_c & (cnt_c == CNT_W'(1))) | range_bad;

    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    inv_nxt       = inv_r;
    res_valid_nxt = res_valid_r & ~res_pop;
    res_mag_nxt   = res_mag_r;
    res_neg_nxt   = res_neg_r;
    res_bad_nxt   = res_bad_r;

    if (take) begin
      if (q_rdata.last) begin
        acc_nxt       = '0;
        cnt_nxt       = '0;
        neg_nxt       = 1'b0;
        inv_nxt       = 1'b0;
        res_valid_nxt = 1'b1;
        res_mag_nxt   = bad ? '0 : acc_c;
        res_neg_nxt   = neg_c & ~bad;
        res_bad_nxt   = bad;
      end else begin
        acc_nxt = acc_c;
        cnt_nxt = cnt_c;
        neg_nxt = neg_c;
        inv_nxt = inv_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      inv_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      inv_r       <= inv_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_mag_r <= res_mag_nxt;
    res_neg_r <= res_neg_nxt;
    res_bad_r <= res_bad_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_mag   = res_mag_r;
  assign res_neg   = res_neg_r;
  assign res_bad   = res_bad_r;

endmodule

// ===== hdl/decimal_int64_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_int64_parser: ASCII decimal text to signed 64-bit integer
// Character-serial parser with overflow and range checking.
// ----------------------------------------------------------------------------
// One request is one character of a decimal number; the character flagged
// in_is_last closes the number and yields one result (value and status),
// other characters yield none. An optional leading minus, then digits only,
// at most MAX_CHARS characters; anything else, a lone minus, unsigned 64-bit
// overflow or a value outside the signed 64-bit range gives status 1 and
// value 0. The block takes one character per clock while the queue is not
// full: the classifier feeds a four-entry queue and the accumulator drains
// one entry per cycle, its multiply-by-ten, add and overflow test being
// combinational. A finished result sits in a one-deep result register;
// while it waits, non-final characters keep flowing and only the next final
// character holds back. An accepted final character passes through the
// queue and then the result register before out_empty goes low.
module decimal_int64_parser #(
  parameter int unsigned MAX_CHARS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  // result channel
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [63:0] out_value,
  output logic               out_status
);

  // classified character heading for the queue
  dip_pkg::q_entry_t q_wdata, q_rdata;
  logic              q_push, q_full, q_pop, q_empty;

  // finished result, magnitude and sign kept apart
  logic              res_valid, res_neg, res_bad;
  logic [63:0]       res_mag;

  // front: classify each character as it arrives
  dip_front u_front (
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // decoupling queue between front and back
  dip_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: accumulate, check and hold the result
  dip_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_mag   (res_mag),
    .res_neg   (res_neg),
    .res_bad   (res_bad),
    .res_pop   (out_pop)
  );

  // the input side only stalls when the queue is full
  assign in_full = q_full;

  // magnitude is already zero on a bad number, so negation gives zero too
  assign out_empty  = ~res_valid;
  assign out_value  = res_neg ? $signed(64'd0 - res_mag) : $signed(res_mag);
  assign out_status = res_bad;

endmodule

// ===== dv/decimal_int64_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_int64_parser_tb: self-checking bench for the decimal parser
// Feeds decimal text one character per request and predicts each result
// in the bench. A directed table covers the range edges, sign handling,
// the length limit and bad characters. Random numbers follow, mostly
// well-formed with some broken text and noise, under varied idle patterns
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module decimal_int64_parser_tb;

  localparam int MAX_CHARS = 20;
  localparam int RAND_CHARS_PER_PHASE = 210;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;

  // result status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  localparam logic signed [63:0] S64_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_BOTTOM = 64'sh8000_0000_0000_0000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic signed [63:0] value;
    logic               status;
  } num_result_t;

  // one directed number: its text, an optional raw code that replaces the
  // first character (for codes a string cannot hold), and a typed result
  typedef struct {
    string              text;
    int                 raw;
    bit                 typed;
    logic signed [63:0] value;
    logic               status;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_char_code;
  logic               in_is_last;
  logic               out_empty;
  logic               out_pop;
  logic signed [63:0] out_value;
  logic               out_status;

  // predictor state, mirrors the parser's per-number registers
  logic [63:0] num_mag = '0;
  int          num_len = 0;
  bit          num_neg = 1'b0;
  bit          num_bad = 1'b0;

  // results still owed by the parser, oldest first
  num_result_t expected_nums[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  bit hold_rx      = 1'b0;
  int chars_sent   = 0;
  int fail_count   = 0;
  int cycle_count  = 0;

  dir_row_t dir_rows[] = '{
    '{"0",                      -1,  1, 64'sd0,     ST_OK},
    '{"-0",                     -1,  1, 64'sd0,     ST_OK},
    '{"9223372036854775807",    -1,  1, S64_TOP,    ST_OK},
    '{"-9223372036854775808",   -1,  1, S64_BOTTOM, ST_OK},
    '{"9223372036854775808",    -1,  1, 64'sd0,     ST_INVALID},
    '{"-9223372036854775809",   -1,  1, 64'sd0,     ST_INVALID},
    '{"18446744073709551615",   -1,  1, 64'sd0,     ST_INVALID},
    '{"18446744073709551616",   -1,  1, 64'sd0,     ST_INVALID},
    '{"99999999999999999999",   -1,  1, 64'sd0,     ST_INVALID},
    '{"-",                      -1,  1, 64'sd0,     ST_INVALID},
    '{"1-2",                    -1,  1, 64'sd0,     ST_INVALID},
    '{"--1",                    -1,  1, 64'sd0,     ST_INVALID},
    '{"00000000000000000042",   -1,  1, 64'sd42,    ST_OK},
    '{"000000000000000000042",  -1,  1, 64'sd0,     ST_INVALID},
    '{"-0000000000000000001",   -1,  1, -64'sd1,    ST_OK},
    '{"-000000000000000000000", -1,  1, 64'sd0,     ST_INVALID},
    '{"/",                      -1,  1, 64'sd0,     ST_INVALID},
    '{":",                      -1,  1, 64'sd0,     ST_INVALID},
    '{"x7",                     0,   1, 64'sd0,     ST_INVALID},
    '{"x",                      255, 1, 64'sd0,     ST_INVALID},
    '{"a12",                    -1,  1, 64'sd0,     ST_INVALID},
    '{"12345",                  -1,  0, 64'sd0,     ST_OK},
    '{"-987654321",             -1,  0, 64'sd0,     ST_OK},
    '{"4294967296",             -1,  0, 64'sd0,     ST_OK}
  };

  decimal_int64_parser #(
    .MAX_CHARS(MAX_CHARS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_char_code(in_char_code),
    .in_is_last  (in_is_last),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_value   (out_value),
    .out_status  (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the parser hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // fold one accepted character into the predictor state; returns 1 and the
  // expected result when the character closes the number
  function automatic bit fold_char(input logic [7:0] c, input bit last,
                                   output num_result_t res);
    logic [63:0] d;
    bit          first;
    bit          bad;
    first = (num_len == 0);
    res.value  = '0;
    res.status = ST_OK;
    // count saturates one past the limit
    if (num_len <= MAX_CHARS) num_len++;
    if (num_len > MAX_CHARS) begin
      num_bad = 1'b1;
    end else if (!num_bad) begin
      if (first && c == dip_pkg::CH_MINUS) begin
        num_neg = 1'b1;
      end else if (!(c inside {[dip_pkg::CH_ZERO:dip_pkg::CH_NINE]})) begin
        num_bad = 1'b1;
      end else begin
        d = 64'(c - dip_pkg::CH_ZERO);
        // times ten plus digit must stay within 64 unsigned bits
        if (num_mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) num_bad = 1'b1;
        else num_mag = num_mag * 64'd10 + d;
      end
    end
    if (!last) return 1'b0;

    // lone minus, then the signed range (one more on the negative side)
    bad = num_bad || (num_neg && num_len == 1);
    if (!bad) begin
      if (num_neg) begin
        if (num_mag > 64'h8000_0000_0000_0000) bad = 1'b1;
        else res.value = 64'd0 - num_mag;
      end else begin
        if (num_mag > 64'h7FFF_FFFF_FFFF_FFFF) bad = 1'b1;
        else res.value = num_mag;
      end
    end
    if (bad) begin
      res.value  = '0;
      res.status = ST_INVALID;
    end
    num_mag = '0;
    num_len = 0;
    num_neg = 1'b0;
    num_bad = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(dip_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  // random number text: mostly well-formed with random content, some near
  // the 64-bit edges and the length limit, the rest broken text or noise
  function automatic byte_q_t make_number();
    byte_q_t     q;
    string       s;
    string       bases [2];
    logic [63:0] u;
    int          kind;
    int          n;
    int          i;
    bases[0] = "922337203685477580";
    bases[1] = "1844674407370955161";
    kind = $urandom_range(99);
    if (kind < 30) begin
      // short number, sometimes negative
      if ($urandom_range(3) == 0) q.push_back(dip_pkg::CH_MINUS);
      n = $urandom_range(1, 6);
      repeat (n) q.push_back(rand_digit());
    end else if (kind < 50) begin
      // any width of magnitude up to the full 64 bits
      u = {$urandom, $urandom} >> $urandom_range(63);
      s = $sformatf("%0d", u);
      if ($urandom_range(1) != 0) q.push_back(dip_pkg::CH_MINUS);
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    end else if (kind < 62) begin
      // right at the signed or unsigned 64-bit boundary
      if ($urandom_range(1) != 0) q.push_back(dip_pkg::CH_MINUS);
      s = bases[$urandom_range(1)];
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
      q.push_back(rand_digit());
      if ($urandom_range(3) == 0) q.push_back(rand_digit());
    end else if (kind < 72) begin
      // leading zeros around the character limit
      if ($urandom_range(1) != 0) q.push_back(dip_pkg::CH_MINUS);
      n = $urandom_range(17, 21);
      repeat (n) q.push_back(dip_pkg::CH_ZERO);
      q.push_back(rand_digit());
    end else if (kind < 87) begin
      // well-formed digits with one character spoilt
      n = $urandom_range(1, 8);
      repeat (n) q.push_back(rand_digit());
      q[$urandom_range(n - 1)] = ($urandom_range(1) != 0) ? dip_pkg::CH_MINUS
                                                          : 8'($urandom_range(255));
    end else begin
      // raw noise, any code
      n = $urandom_range(1, 22);
      repeat (n) q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  // offer one character and wait for the request to be taken; push stays
  // high between back-to-back requests and only drops for an idle gap
  task automatic offer_char(input logic [7:0] c, input bit last,
                            output bit got, output num_result_t res);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    do @(posedge clk); while (in_full);
    got = fold_char(c, last, res);
    chars_sent++;
  endtask

  // send a whole number; the closing character yields the expectation,
  // taken from the table where it is typed in, else from the predictor
  task automatic send_number(input byte_q_t txt, input bit typed,
                             input num_result_t typed_res);
    num_result_t res;
    bit          got;
    got = 1'b0;
    foreach (txt[i]) offer_char(txt[i], i == txt.size() - 1, got, res);
    if (got) expected_nums.push_back(typed ? typed_res : res);
  endtask

  // receiver: pops at random, checks each popped result against the oldest
  // expectation
  initial begin
    num_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (expected_nums.size() == 0) begin
          $error("result with nothing expected: value %0d status %0b",
                 out_value, out_status);
          fail_count++;
        end else begin
          want = expected_nums.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_value);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, out_status);
            fail_count++;
          end
        end
      end
      out_pop <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the result register and the queue fill up
  // and the parser has to stall its input
  initial begin
    wait (hold_req);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // main sequence: reset, directed table, random phases, drain
  initial begin
    byte_q_t     txt;
    num_result_t typed_res;
    int          i;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_char_code = '0;
    in_is_last   = 1'b0;
    out_pop      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling on either side
    foreach (dir_rows[r]) begin
      txt = {};
      for (i = 0; i < dir_rows[r].text.len(); i++) txt.push_back(dir_rows[r].text[i]);
      if (dir_rows[r].raw >= 0) txt[0] = 8'(dir_rows[r].raw);
      typed_res.value  = dir_rows[r].value;
      typed_res.status = dir_rows[r].status;
      send_number(txt, dir_rows[r].typed, typed_res);
    end

    // random part: free running with the hold-off, then sender gaps,
    // receiver stalls, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_req     = 1'b1;
        end
        1: begin
          tx_idle_pct  = 46;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 46;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      chars_sent = 0;
      while (chars_sent < RAND_CHARS_PER_PHASE) send_number(make_number(), 1'b0, typed_res);
    end
    in_push <= 1'b0;

    // wait for every owed result, then DRAIN_CYCLES more for strays
    while (expected_nums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dip_pkg.sv
hdl/dip_front.sv
hdl/dip_queue.sv
hdl/dip_back.sv
hdl/decimal_int64_parser.sv
dv/decimal_int64_parser_tb.sv
